// ===== rtl/hpd_pkg.sv =====
`default_nettype none

package hpd_pkg;

  localparam int PIX_W        = 16;
  localparam int POS_X_W      = 13;
  localparam int POS_Y_W      = 14;
  localparam int CFG_W        = 15;
  localparam int WIDTH_CFG_W  = 14;
  localparam int HEIGHT_CFG_W = 15;
  localparam int DEPTH_CFG_W  = 5;

  localparam logic [WIDTH_CFG_W-1:0]  WIDTH_RESET  = 14'd8192;
  localparam logic [HEIGHT_CFG_W-1:0] HEIGHT_RESET = 15'd16384;
  localparam logic [DEPTH_CFG_W-1:0]  DEPTH_RESET  = 5'd14;

  // A neighbor passes when 25 * neighbor <= 13 * center (the 0.52 ratio).
  localparam int NEIGH_MUL  = 25;
  localparam int CENTER_MUL = 13;
  localparam int PROD_W     = 21;

  localparam int FIFO_DEPTH = 8;
  localparam int FIFO_PTR_W = 3;
  localparam int FIFO_CNT_W = 4;

  typedef enum logic [1:0] {
    CFG_IMAGE_WIDTH  = 2'd0,
    CFG_IMAGE_HEIGHT = 2'd1,
    CFG_BIT_DEPTH    = 2'd2
  } cfg_index_t;

  typedef enum logic [1:0] {
    OP_NONE  = 2'd0,
    OP_PIXEL = 2'd1,
    OP_LOAD  = 2'd2
  } op_t;

  typedef logic [PIX_W-1:0] pix_t;

  typedef pix_t [2:0][2:0] win_t;

  typedef struct packed {
    logic               vld;
    logic [POS_X_W-1:0] pos_x;
    logic [POS_Y_W-1:0] pos_y;
    logic               done;
    logic [2:0]         rows;
    logic [2:0]         cols;
  } req_t;

  typedef struct packed {
    logic [POS_X_W-1:0] pos_x;
    logic [POS_Y_W-1:0] pos_y;
    logic               is_candidate;
    logic               frame_done;
  } res_t;

  // Saturation threshold floor(4 * (2^d - 1) / 5), depths above 16 act as 16.
  function automatic pix_t sat_threshold(input logic [DEPTH_CFG_W-1:0] d);
    pix_t thr;
    unique case (d)
      5'd0:    thr = 16'd0;
      5'd1:    thr = 16'd0;
      5'd2:    thr = 16'd2;
      5'd3:    thr = 16'd5;
      5'd4:    thr = 16'd12;
      5'd5:    thr = 16'd24;
      5'd6:    thr = 16'd50;
      5'd7:    thr = 16'd101;
      5'd8:    thr = 16'd204;
      5'd9:    thr = 16'd408;
      5'd10:   thr = 16'd818;
      5'd11:   thr = 16'd1637;
      5'd12:   thr = 16'd3276;
      5'd13:   thr = 16'd6552;
      5'd14:   thr = 16'd13106;
      5'd15:   thr = 16'd26213;
      default: thr = 16'd52428;
    endcase
    return thr;
  endfunction

endpackage

`default_nettype wire

// ===== rtl/hot_pixel_candidate_detector.sv =====
// A verdict passes through the s1 and s2 request registers and then the result FIFO before it reaches the output.
// Throughput: one word per cycle; input stalls while the window is preloaded after the frame's last pixel,
// while it is realigned when a narrowed width leaves the drain past the last column,
// and while the 8-word result FIFO cannot hold every result still in flight.
// Synchronous reset clears counters, the window and the FIFO and restores the configuration
// defaults; the line store is not cleared and is always written before it is used.
`default_nettype none

module hot_pixel_candidate_detector
  import hpd_pkg::*;
#(
  parameter int MAX_WIDTH  = 8192,
  parameter int MAX_HEIGHT = 16384
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               item_valid,
  output logic               item_stall,
  input  logic               kind,
  input  logic [PIX_W-1:0]   pixel_value,
  output logic               result_valid,
  input  logic               result_stall,
  output logic [POS_X_W-1:0] pos_x,
  output logic [POS_Y_W-1:0] pos_y,
  output logic               is_candidate,
  output logic               frame_done,
  input  logic               cfg_write,
  input  logic [1:0]         cfg_index,
  input  logic [CFG_W-1:0]   cfg_data
);

  localparam int XW     = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
  localparam int YW     = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;
  localparam int ROOM_W = FIFO_CNT_W + 1;

  logic [WIDTH_CFG_W-1:0]  cfg_width;
  logic [HEIGHT_CFG_W-1:0] cfg_height;
  logic [DEPTH_CFG_W-1:0]  cfg_depth;
  logic [XW-1:0]           w_last;
  logic [YW-1:0]           h_last;
  pix_t                    thr;

  logic [XW-1:0] column_count, column_count_next;
  logic [YW-1:0] row_count, row_count_next;
  logic [XW-1:0] drain_count, drain_count_next;
  logic          draining, draining_next;
  logic          preload, preload_next;
  logic          realign, realign_next;
  logic          misaligned;

  logic          accept;
  logic          pixel_go;
  logic          drain_go;
  logic [XW-1:0] x, k;
  logic [YW-1:0] y;
  logic          x_last, y_last, k_last;
  op_t           op0;
  logic [XW-1:0] addr0;
  req_t [1:0]    req0;

  op_t           s1_op;
  logic [XW-1:0] s1_addr;
  pix_t          s1_pix;
  req_t [1:0]    s1_req;
  req_t [1:0]    s2_req;

  logic [2*PIX_W-1:0] line_mem [MAX_WIDTH];
  logic [2*PIX_W-1:0] rd_data;
  logic [2*PIX_W-1:0] fwd_data;
  logic               fwd;
  logic               fwd_next;
  logic [2*PIX_W-1:0] entry;
  logic [2*PIX_W-1:0] wdata;

  win_t window;
  win_t win_shift;
  logic verdict0, verdict1;

  logic [1:0]            push;
  res_t [1:0]            push_word;
  logic                  pop;
  logic                  fifo_not_empty;
  res_t                  fifo_head;
  logic [FIFO_CNT_W-1:0] fifo_count;
  logic [2:0]            inflight;
  logic [ROOM_W-1:0]     demand;
  logic                  room;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg_width  <= WIDTH_RESET;
      cfg_height <= HEIGHT_RESET;
      cfg_depth  <= DEPTH_RESET;
    end else if (cfg_write) begin
      unique case (cfg_index)
        CFG_IMAGE_WIDTH:  cfg_width  <= cfg_data[WIDTH_CFG_W-1:0];
        CFG_IMAGE_HEIGHT: cfg_height <= cfg_data[HEIGHT_CFG_W-1:0];
        CFG_BIT_DEPTH:    cfg_depth  <= cfg_data[DEPTH_CFG_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    if (cfg_width == '0) begin
      w_last = '0;
    end else if (32'(cfg_width) > 32'(MAX_WIDTH)) begin
      w_last = XW'(MAX_WIDTH - 1);
    end else begin
      w_last = XW'(32'(cfg_width) - 32'd1);
    end
    if (cfg_height == '0) begin
      h_last = '0;
    end else if (32'(cfg_height) > 32'(MAX_HEIGHT)) begin
      h_last = YW'(MAX_HEIGHT - 1);
    end else begin
      h_last = YW'(32'(cfg_height) - 32'd1);
    end
    thr = sat_threshold(cfg_depth);
  end

  assign inflight = 3'(s1_req[0].vld) + 3'(s1_req[1].vld) +
                    3'(s2_req[0].vld) + 3'(s2_req[1].vld);
  assign demand   = ROOM_W'(fifo_count) + ROOM_W'(inflight) + ROOM_W'(2);
  assign room     = (demand <= ROOM_W'(FIFO_DEPTH));

  // The window only tracks the drain position while it lies inside the row.
  assign misaligned = draining && (drain_count > w_last);

  assign item_stall = preload || realign || misaligned || !room;
  assign accept     = item_valid && !item_stall;
  assign pixel_go   = accept && !kind && !draining;
  assign drain_go   = accept && kind && draining;

  always_comb begin
    x      = (column_count > w_last) ? w_last : column_count;
    y      = (row_count > h_last) ? h_last : row_count;
    k      = (drain_count > w_last) ? w_last : drain_count;
    x_last = (x == w_last);
    y_last = (y == h_last);
    k_last = (k == w_last);

    column_count_next = column_count;
    row_count_next    = row_count;
    drain_count_next  = drain_count;
    draining_next     = draining;
    preload_next      = 1'b0;
    realign_next      = 1'b0;
    op0               = OP_NONE;
    addr0             = x;
    req0              = '0;

    if (preload) begin
      op0   = OP_LOAD;
      addr0 = '0;
    end else if (realign) begin
      op0              = OP_LOAD;
      addr0            = w_last;
      drain_count_next = w_last;
    end else if (misaligned) begin
      op0          = OP_LOAD;
      addr0        = (w_last == '0) ? '0 : XW'(w_last - 1'b1);
      realign_next = 1'b1;
    end else if (pixel_go) begin
      op0   = OP_PIXEL;
      addr0 = x;

      req0[0].vld   = (y != '0) && (x != '0);
      req0[0].pos_x = POS_X_W'(x - 1'b1);
      req0[0].pos_y = POS_Y_W'(y - 1'b1);
      req0[0].rows  = {1'b1, 1'b1, (y > YW'(1))};
      req0[0].cols  = {1'b1, 1'b1, (x > XW'(1))};

      req0[1].vld   = (y != '0) && x_last;
      req0[1].pos_x = POS_X_W'(x);
      req0[1].pos_y = POS_Y_W'(y - 1'b1);
      req0[1].rows  = {1'b1, 1'b1, (y > YW'(1))};
      req0[1].cols  = {1'b0, 1'b1, (x != '0)};

      if (x_last) begin
        column_count_next = '0;
        if (y_last) begin
          row_count_next   = y;
          draining_next    = 1'b1;
          drain_count_next = '0;
          preload_next     = 1'b1;
        end else begin
          row_count_next = YW'(y + 1'b1);
        end
      end else begin
        column_count_next = XW'(x + 1'b1);
        row_count_next    = y;
      end
    end else if (drain_go) begin
      op0   = OP_LOAD;
      addr0 = k_last ? k : XW'(k + 1'b1);

      req0[0].vld   = 1'b1;
      req0[0].pos_x = POS_X_W'(k);
      req0[0].pos_y = POS_Y_W'(row_count);
      req0[0].done  = k_last;
      req0[0].rows  = {1'b0, 1'b1, (row_count != '0)};
      req0[0].cols  = {!k_last, 1'b1, (k != '0)};

      if (k_last) begin
        draining_next     = 1'b0;
        drain_count_next  = '0;
        row_count_next    = '0;
        column_count_next = '0;
      end else begin
        drain_count_next = XW'(k + 1'b1);
      end
    end
  end

  assign fwd_next = (s1_op == OP_PIXEL) && (op0 != OP_NONE) && (addr0 == s1_addr);

  always_ff @(posedge clk) begin
    if (rst) begin
      column_count <= '0;
      row_count    <= '0;
      drain_count  <= '0;
      draining     <= 1'b0;
      preload      <= 1'b0;
      realign      <= 1'b0;
      s1_op        <= OP_NONE;
      s1_req       <= '0;
      s2_req       <= '0;
      fwd          <= 1'b0;
    end else begin
      column_count <= column_count_next;
      row_count    <= row_count_next;
      drain_count  <= drain_count_next;
      draining     <= draining_next;
      preload      <= preload_next;
      realign      <= realign_next;
      s1_op        <= op0;
      s1_req       <= req0;
      s2_req       <= s1_req;
      fwd          <= fwd_next;
    end
  end

  always_ff @(posedge clk) begin
    s1_addr <= addr0;
    s1_pix  <= pixel_value;
  end

  // Each entry holds the pixel two rows up in its upper half and one row up in its lower half.
  assign entry = fwd ? fwd_data : rd_data;
  assign wdata = {entry[PIX_W-1:0], s1_pix};

  always_ff @(posedge clk) begin
    rd_data  <= line_mem[addr0];
    fwd_data <= wdata;
    if (s1_op == OP_PIXEL) begin
      line_mem[s1_addr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      window <= '0;
    end else if (s1_op != OP_NONE) begin
      for (int r = 0; r < 3; r++) begin
        window[r][0] <= window[r][1];
        window[r][1] <= window[r][2];
      end
      window[0][2] <= entry[2*PIX_W-1:PIX_W];
      window[1][2] <= entry[PIX_W-1:0];
      window[2][2] <= s1_pix;
    end
  end

  always_comb begin
    for (int r = 0; r < 3; r++) begin
      win_shift[r][0] = window[r][1];
      win_shift[r][1] = window[r][2];
      win_shift[r][2] = '0;
    end
  end

  hpd_judge u_judge0 (
    .win     (window),
    .rows    (s2_req[0].rows),
    .cols    (s2_req[0].cols),
    .thr     (thr),
    .verdict (verdict0)
  );

  hpd_judge u_judge1 (
    .win     (win_shift),
    .rows    (s2_req[1].rows),
    .cols    (s2_req[1].cols),
    .thr     (thr),
    .verdict (verdict1)
  );

  always_comb begin
    push                      = {s2_req[1].vld, s2_req[0].vld};
    push_word[0].pos_x        = s2_req[0].pos_x;
    push_word[0].pos_y        = s2_req[0].pos_y;
    push_word[0].is_candidate = verdict0;
    push_word[0].frame_done   = s2_req[0].done;
    push_word[1].pos_x        = s2_req[1].pos_x;
    push_word[1].pos_y        = s2_req[1].pos_y;
    push_word[1].is_candidate = verdict1;
    push_word[1].frame_done   = s2_req[1].done;
  end

  assign pop = fifo_not_empty && !result_stall;

  hpd_out_fifo u_out_fifo (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_word (push_word),
    .pop       (pop),
    .not_empty (fifo_not_empty),
    .head      (fifo_head),
    .count     (fifo_count)
  );

  assign result_valid = fifo_not_empty;
  assign pos_x        = fifo_head.pos_x;
  assign pos_y        = fifo_head.pos_y;
  assign is_candidate = fifo_head.is_candidate;
  assign frame_done   = fifo_head.frame_done;

  a_fifo_no_overflow: assert property (@(posedge clk) disable iff (rst)
    (ROOM_W'(fifo_count) + ROOM_W'(s2_req[0].vld) + ROOM_W'(s2_req[1].vld))
      <= ROOM_W'(FIFO_DEPTH))
    else $error("Result FIFO would overflow.");

  a_load_while_draining: assert property (@(posedge clk) disable iff (rst)
    (s1_op == OP_LOAD) |-> $past(draining))
    else $error("Line store load outside the drain phase.");

  a_pixel_not_in_drain: assert property (@(posedge clk) disable iff (rst)
    (s1_op == OP_PIXEL) |-> $past(!draining))
    else $error("Pixel entered the pipeline while draining.");

endmodule

`default_nettype wire

// ===== rtl/hpd_judge.sv =====
`default_nettype none

module hpd_judge
  import hpd_pkg::*;
(
  input  win_t       win,
  input  logic [2:0] rows,
  input  logic [2:0] cols,
  input  pix_t       thr,
  output logic       verdict
);

  logic [PROD_W-1:0] center_prod;
  logic [8:0]        over;

  always_comb begin
    center_prod = PROD_W'(win[1][1]) * PROD_W'(CENTER_MUL);
    for (int r = 0; r < 3; r++) begin
      for (int c = 0; c < 3; c++) begin
        over[r*3+c] = rows[r] && cols[c] && !(r == 1 && c == 1) &&
                      ((PROD_W'(win[r][c]) * PROD_W'(NEIGH_MUL)) > center_prod);
      end
    end
  end

  assign verdict = (win[1][1] >= thr) && (over == '0);

endmodule

`default_nettype wire

// ===== rtl/hpd_out_fifo.sv =====
`default_nettype none

module hpd_out_fifo
  import hpd_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic [1:0]            push,
  input  res_t [1:0]            push_word,
  input  logic                  pop,
  output logic                  not_empty,
  output res_t                  head,
  output logic [FIFO_CNT_W-1:0] count
);

  res_t                  store [FIFO_DEPTH];
  logic [FIFO_PTR_W-1:0] wr_ptr;
  logic [FIFO_PTR_W-1:0] rd_ptr;
  logic [FIFO_PTR_W-1:0] second_ptr;
  logic [FIFO_CNT_W-1:0] n_push;
  logic [FIFO_CNT_W-1:0] n_pop;

  assign n_push     = FIFO_CNT_W'(push[0]) + FIFO_CNT_W'(push[1]);
  assign n_pop      = FIFO_CNT_W'(pop);
  assign second_ptr = push[0] ? FIFO_PTR_W'(wr_ptr + 1'b1) : wr_ptr;
  assign not_empty  = (count != '0);
  assign head       = store[rd_ptr];

  always_ff @(posedge clk) begin
    if (push[0]) begin
      store[wr_ptr] <= push_word[0];
    end
    if (push[1]) begin
      store[second_ptr] <= push_word[1];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      wr_ptr <= FIFO_PTR_W'(wr_ptr + n_push);
      rd_ptr <= FIFO_PTR_W'(rd_ptr + n_pop);
      count  <= FIFO_CNT_W'(count + n_push - n_pop);
    end
  end

endmodule

`default_nettype wire

// ===== tb/tb_hot_pixel_candidate_detector.sv =====
`timescale 1ns / 1ps

module tb_hot_pixel_candidate_detector;
  import hpd_pkg::*;

  localparam int LINE_MAX = 8192;
  localparam int ROWS_MAX = 16384;
  localparam bit KIND_PIXEL = 1'b0;
  localparam bit KIND_DRAIN = 1'b1;
  localparam int SETTLE_CYCLES = 6;
  localparam int CYCLE_LIMIT = 2000000;
  localparam int RANDOM_WORDS = 550;

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               item_valid = 1'b0;
  logic               item_stall;
  logic               kind = KIND_PIXEL;
  logic [PIX_W-1:0]   pixel_value = '0;
  logic               result_valid;
  logic               result_stall = 1'b0;
  logic [POS_X_W-1:0] pos_x;
  logic [POS_Y_W-1:0] pos_y;
  logic               is_candidate;
  logic               frame_done;
  logic               cfg_write = 1'b0;
  logic [1:0]         cfg_index = '0;
  logic [CFG_W-1:0]   cfg_data = '0;

  bit [PIX_W-1:0] row_above [LINE_MAX];
  bit [PIX_W-1:0] row_above2 [LINE_MAX];
  win_t           pix_win;
  int unsigned    col_cnt;
  int unsigned    row_cnt;
  int unsigned    drain_cnt;
  bit             draining;
  int unsigned    width_reg;
  int unsigned    height_reg;
  int unsigned    depth_reg;

  res_t        pending_verdicts[$];
  int unsigned fail_count = 0;
  int unsigned burst_left = 0;
  int unsigned words_counted = 0;
  int unsigned cycle_count = 0;
  int unsigned stall_run = 0;
  bit          stall_now = 1'b0;

  always #4 clk = ~clk;

  hot_pixel_candidate_detector u_top (
    .clk          (clk),
    .rst          (rst),
    .item_valid   (item_valid),
    .item_stall   (item_stall),
    .kind         (kind),
    .pixel_value  (pixel_value),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .pos_x        (pos_x),
    .pos_y        (pos_y),
    .is_candidate (is_candidate),
    .frame_done   (frame_done),
    .cfg_write    (cfg_write),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data)
  );

  function automatic int unsigned live_width();
    if (width_reg < 1) return 1;
    if (width_reg > LINE_MAX) return LINE_MAX;
    return width_reg;
  endfunction

  function automatic int unsigned live_height();
    if (height_reg < 1) return 1;
    if (height_reg > ROWS_MAX) return ROWS_MAX;
    return height_reg;
  endfunction

  function automatic int unsigned depth_max();
    int unsigned d;
    d = (depth_reg > 16) ? 16 : depth_reg;
    return (1 << d) - 1;
  endfunction

  function automatic int unsigned sat_level();
    return (4 * depth_max()) / 5;
  endfunction

  function automatic bit hot_candidate(input win_t wv, input bit [2:0] rows,
                                       input bit [2:0] cols);
    int unsigned center;
    int unsigned nb;
    center = wv[1][1];
    if (center < sat_level()) return 1'b0;
    for (int r = 0; r < 3; r++) begin
      for (int c = 0; c < 3; c++) begin
        nb = wv[r][c];
        if (rows[r] && cols[c] && !(r == 1 && c == 1) && NEIGH_MUL * nb > CENTER_MUL * center)
          return 1'b0;
      end
    end
    return 1'b1;
  endfunction

  function automatic void push_verdict(input int unsigned x, input int unsigned y,
                                       input bit cand, input bit done);
    res_t v;
    v.pos_x = POS_X_W'(x);
    v.pos_y = POS_Y_W'(y);
    v.is_candidate = cand;
    v.frame_done = done;
    pending_verdicts.insert(pending_verdicts.size(), v);
  endfunction

  // Returns 1 when the word changes the block's state, 0 when it is ignored.
  function automatic bit predict_verdicts(input bit k, input logic [PIX_W-1:0] pix);
    int unsigned w;
    int unsigned h;
    int unsigned x;
    int unsigned y;
    int unsigned kc;
    int unsigned col;
    bit [PIX_W-1:0] above;
    bit [PIX_W-1:0] above2;
    win_t side_win;
    bit [2:0] rows;
    bit [2:0] cols;
    w = live_width();
    h = live_height();
    if (k == KIND_DRAIN) begin
      if (!draining) return 1'b0;
      kc = (drain_cnt >= w) ? w - 1 : drain_cnt;
      y = row_cnt;
      side_win = '0;
      cols = '0;
      for (int c = 0; c < 3; c++) begin
        col = kc + c;
        if (col >= 1 && col - 1 < w) begin
          cols[c] = 1'b1;
          side_win[0][c] = row_above2[col-1];
          side_win[1][c] = row_above[col-1];
        end
      end
      rows = 3'b010;
      rows[0] = (y >= 1);
      push_verdict(kc, y, hot_candidate(side_win, rows, cols), kc == w - 1);
      if (kc == w - 1) begin
        draining = 1'b0;
        drain_cnt = 0;
        row_cnt = 0;
        col_cnt = 0;
      end else begin
        drain_cnt = kc + 1;
      end
      return 1'b1;
    end
    if (draining) return 1'b0;
    x = (col_cnt >= w) ? w - 1 : col_cnt;
    y = (row_cnt >= h) ? h - 1 : row_cnt;
    above = row_above[x];
    above2 = row_above2[x];
    row_above2[x] = above;
    row_above[x] = pix;
    for (int r = 0; r < 3; r++) begin
      pix_win[r][0] = pix_win[r][1];
      pix_win[r][1] = pix_win[r][2];
    end
    pix_win[0][2] = above2;
    pix_win[1][2] = above;
    pix_win[2][2] = pix;
    rows = 3'b110;
    rows[0] = (y >= 2);
    if (y >= 1 && x >= 1) begin
      cols = 3'b110;
      cols[0] = (x >= 2);
      push_verdict(x - 1, y - 1, hot_candidate(pix_win, rows, cols), 1'b0);
    end
    if (y >= 1 && x == w - 1) begin
      side_win = '0;
      for (int r = 0; r < 3; r++) begin
        side_win[r][0] = pix_win[r][1];
        side_win[r][1] = pix_win[r][2];
      end
      cols = 3'b010;
      cols[0] = (x >= 1);
      push_verdict(x, y - 1, hot_candidate(side_win, rows, cols), 1'b0);
    end
    if (x == w - 1) begin
      col_cnt = 0;
      if (y == h - 1) begin
        row_cnt = y;
        draining = 1'b1;
        drain_cnt = 0;
      end else begin
        row_cnt = y + 1;
      end
    end else begin
      col_cnt = x + 1;
      row_cnt = y;
    end
    return 1'b1;
  endfunction

  function automatic logic [PIX_W-1:0] pick_pixel();
    int unsigned thr;
    int unsigned sel;
    thr = sat_level();
    sel = $urandom_range(0, 99);
    if (sel < 60) return PIX_W'($urandom_range(0, thr / 2));
    if (sel < 80) return PIX_W'($urandom_range(thr, depth_max()));
    if (sel < 88) begin
      case ($urandom_range(0, 2))
        0: return PIX_W'(thr);
        1: return PIX_W'((thr > 0) ? thr - 1 : 0);
        default: return PIX_W'(depth_max());
      endcase
    end
    return PIX_W'($urandom_range(0, 65535));
  endfunction

  task automatic write_reg(input cfg_index_t idx, input int unsigned value);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data <= CFG_W'(value);
    @(negedge clk);
    cfg_write <= 1'b0;
    case (idx)
      CFG_IMAGE_WIDTH:  width_reg = value & ((1 << WIDTH_CFG_W) - 1);
      CFG_IMAGE_HEIGHT: height_reg = value & ((1 << HEIGHT_CFG_W) - 1);
      CFG_BIT_DEPTH:    depth_reg = value & ((1 << DEPTH_CFG_W) - 1);
      default: ;
    endcase
    @(negedge clk);
  endtask

  task automatic set_frame(input int unsigned w, input int unsigned h, input int unsigned d);
    write_reg(CFG_IMAGE_WIDTH, w);
    write_reg(CFG_IMAGE_HEIGHT, h);
    write_reg(CFG_BIT_DEPTH, d);
  endtask

  task automatic send_word(input bit k, input logic [PIX_W-1:0] pix);
    int unsigned gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      if (gap > 0) begin
        item_valid <= 1'b0;
        repeat (gap) @(negedge clk);
      end
      burst_left = $urandom_range(1, 20);
    end
    burst_left--;
    item_valid <= 1'b1;
    kind <= k;
    pixel_value <= pix;
    @(posedge clk);
    while (item_stall) @(posedge clk);
    if (predict_verdicts(k, pix)) words_counted++;
    @(negedge clk);
  endtask

  task automatic settle();
    item_valid <= 1'b0;
    while (pending_verdicts.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
    burst_left = 0;
  endtask

  task automatic stream_frame(input bit noisy);
    int unsigned w;
    int unsigned h;
    w = live_width();
    h = live_height();
    for (int unsigned i = 0; i < w * h; i++) begin
      if (noisy && $urandom_range(0, 29) == 0) send_word(KIND_DRAIN, pick_pixel());
      send_word(KIND_PIXEL, pick_pixel());
    end
    for (int unsigned i = 0; i < w; i++) begin
      if (noisy && $urandom_range(0, 19) == 0) send_word(KIND_PIXEL, pick_pixel());
      send_word(KIND_DRAIN, PIX_W'($urandom_range(0, 65535)));
    end
  endtask

  task automatic test_ignored_words();
    settle();
    set_frame(3, 1, 8);
    send_word(KIND_DRAIN, 16'hFFFF);
    send_word(KIND_PIXEL, 16'hFFFF);
    send_word(KIND_PIXEL, 16'h0000);
    send_word(KIND_PIXEL, 16'd255);
    send_word(KIND_PIXEL, 16'hFFFF);
    send_word(KIND_DRAIN, 16'h0000);
    // Narrowing the row mid-drain makes the next drain word the last column.
    settle();
    write_reg(CFG_IMAGE_WIDTH, 1);
    send_word(KIND_DRAIN, 16'h0000);
  endtask

  task automatic test_neighbor_ratio();
    settle();
    set_frame(1, 4, 31);
    send_word(KIND_PIXEL, 16'd65535);
    send_word(KIND_PIXEL, 16'd34078);
    send_word(KIND_PIXEL, 16'd65535);
    send_word(KIND_PIXEL, 16'd34079);
    send_word(KIND_DRAIN, 16'h0000);
  endtask

  task automatic test_threshold();
    settle();
    set_frame(3, 1, 14);
    send_word(KIND_PIXEL, 16'd13106);
    send_word(KIND_PIXEL, 16'd0);
    send_word(KIND_PIXEL, 16'd13105);
    repeat (3) send_word(KIND_DRAIN, 16'h0000);
  endtask

  task automatic test_shrunk_config();
    settle();
    set_frame(3, 3, 10);
    repeat (5) send_word(KIND_PIXEL, pick_pixel());
    settle();
    write_reg(CFG_IMAGE_WIDTH, 0);
    send_word(KIND_PIXEL, pick_pixel());
    settle();
    write_reg(CFG_IMAGE_HEIGHT, 2);
    send_word(KIND_PIXEL, pick_pixel());
    send_word(KIND_DRAIN, 16'h0000);
  endtask

  task automatic test_random_frames();
    words_counted = 0;
    while (words_counted < RANDOM_WORDS) begin
      settle();
      set_frame(($urandom_range(0, 9) == 0) ? 0 : $urandom_range(1, 12),
                ($urandom_range(0, 9) == 0) ? 0 : $urandom_range(1, 6),
                $urandom_range(0, 31));
      repeat ($urandom_range(1, 3)) stream_frame($urandom_range(0, 1));
    end
  endtask

  task automatic test_widest_row();
    settle();
    set_frame(16383, 2, 12);
    repeat (40) send_word(KIND_PIXEL, pick_pixel());
    // The over-wide row is clamped to 8192 columns; narrowing the width to 41 ends it at the next pixel.
    settle();
    write_reg(CFG_IMAGE_WIDTH, 41);
    repeat (42) send_word(KIND_PIXEL, pick_pixel());
    repeat (41) send_word(KIND_DRAIN, 16'h0000);
  endtask

  task automatic test_tallest_column();
    settle();
    set_frame(1, 32767, 9);
    repeat (30) send_word(KIND_PIXEL, pick_pixel());
    settle();
    write_reg(CFG_IMAGE_HEIGHT, 30);
    send_word(KIND_PIXEL, pick_pixel());
    send_word(KIND_DRAIN, 16'h0000);
  endtask

  always @(negedge clk) begin
    if (stall_run == 0) begin
      if (stall_now) begin
        stall_now = 1'b0;
        stall_run = ($urandom_range(0, 4) == 0) ? $urandom_range(20, 60) : $urandom_range(1, 10);
      end else begin
        stall_now = 1'b1;
        stall_run = $urandom_range(1, 5);
      end
    end
    stall_run--;
    result_stall <= stall_now;
  end

  always @(posedge clk) begin : check_results
    res_t want;
    if (!rst && result_valid && !result_stall) begin
      if (pending_verdicts.size() == 0) begin
        $error("unexpected result word at pos_x=%0d pos_y=%0d", pos_x, pos_y);
        fail_count++;
      end else begin
        want = pending_verdicts.pop_front();
        if (pos_x !== want.pos_x) begin
          $error("pos_x mismatch: expected %0d, got %0d", want.pos_x, pos_x);
          fail_count++;
        end
        if (pos_y !== want.pos_y) begin
          $error("pos_y mismatch: expected %0d, got %0d", want.pos_y, pos_y);
          fail_count++;
        end
        if (is_candidate !== want.is_candidate) begin
          $error("is_candidate mismatch: expected %0d, got %0d", want.is_candidate,
                 is_candidate);
          fail_count++;
        end
        if (frame_done !== want.frame_done) begin
          $error("frame_done mismatch: expected %0d, got %0d", want.frame_done, frame_done);
          fail_count++;
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  initial begin
    pix_win = '0;
    col_cnt = 0;
    row_cnt = 0;
    drain_cnt = 0;
    draining = 1'b0;
    width_reg = WIDTH_RESET;
    height_reg = HEIGHT_RESET;
    depth_reg = DEPTH_RESET;
    repeat (8) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);
    test_ignored_words();
    test_neighbor_ratio();
    test_threshold();
    test_shrunk_config();
    test_random_frames();
    test_widest_row();
    test_tallest_column();
    settle();
    repeat (20) @(negedge clk);
    if (fail_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

// ===== hot_pixel_candidate_detector.f =====
rtl/hpd_pkg.sv
rtl/hpd_judge.sv
rtl/hpd_out_fifo.sv
rtl/hot_pixel_candidate_detector.sv
tb/tb_hot_pixel_candidate_detector.sv
